// ===== sv/thm_pkg.sv =====
// Shared types and codes for the task heartbeat monitor.
`default_nettype none

package thm_pkg;

    localparam int NAME_LO_W  = 64;
    localparam int NAME_HI_W  = 56;
    localparam int NAME_W     = NAME_LO_W + NAME_HI_W;
    localparam int NAME_BYTES = 15;
    localparam int TIME_W     = 32;
    localparam int USED_W     = 4;
    localparam int KIND_W     = 2;
    localparam int STATUS_W   = 3;

    localparam logic [KIND_W-1:0] KIND_REG   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_BEAT  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CHECK = 2'd2;
    localparam logic [KIND_W-1:0] KIND_TICK  = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_EXISTS  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_UNKNOWN = 3'd3;
    localparam logic [STATUS_W-1:0] ST_OVERDUE = 3'd4;

    // Request token that walks the row of slot cells
    typedef struct packed {
        logic [KIND_W-1:0]    kind;
        logic [NAME_LO_W-1:0] name_lo;
        logic [NAME_HI_W-1:0] name_hi;
        logic [TIME_W-1:0]    tmo;
        logic [TIME_W-1:0]    now;
        logic [USED_W-1:0]    used;
        logic                 found;
        logic                 fail;
        logic [NAME_LO_W-1:0] fail_lo;
        logic [NAME_HI_W-1:0] fail_hi;
    } tok_t;

endpackage

`default_nettype wire

// ===== sv/thm_cell.sv =====
// One task slot: stores a name, timeout and last beat, and updates the passing token.
`default_nettype none

module thm_cell #(
    parameter int INDEX = 0
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    input  wire thm_pkg::tok_t in_tok,
    output logic              out_valid,
    output thm_pkg::tok_t     out_tok
);
    import thm_pkg::*;

    localparam logic [USED_W-1:0] SLOT_ID = USED_W'(INDEX);

    logic [NAME_LO_W-1:0] name_lo_reg, name_lo_next;
    logic [NAME_HI_W-1:0] name_hi_reg, name_hi_next;
    logic [TIME_W-1:0]    tmo_reg, tmo_next;
    logic [TIME_W-1:0]    beat_reg, beat_next;
    logic                 valid_reg, valid_next;
    tok_t                 tok_reg, tok_next;

    logic                 active;
    logic                 match;
    logic [TIME_W-1:0]    elapsed;
    logic                 over;

    assign active  = in_valid && (SLOT_ID < in_tok.used);
    assign match   = (name_lo_reg == in_tok.name_lo) && (name_hi_reg == in_tok.name_hi);
    assign elapsed = in_tok.now - beat_reg;
    assign over    = elapsed > tmo_reg;

    always_comb
    begin
        name_lo_next = name_lo_reg;
        name_hi_next = name_hi_reg;
        tmo_next     = tmo_reg;
        beat_next    = beat_reg;
        valid_next   = in_valid;
        tok_next     = in_tok;
        case (in_tok.kind)
            KIND_REG:
            begin
                if (active && match)
                begin
                    tok_next.found = 1'b1;
                end
                // first free slot: every used slot has already been compared
                if (in_valid && (SLOT_ID == in_tok.used) && !in_tok.found)
                begin
                    name_lo_next = in_tok.name_lo;
                    name_hi_next = in_tok.name_hi;
                    tmo_next     = in_tok.tmo;
                    beat_next    = in_tok.now;
                end
            end
            KIND_BEAT:
            begin
                if (active && match && !in_tok.found)
                begin
                    beat_next      = in_tok.now;
                    tok_next.found = 1'b1;
                end
            end
            KIND_CHECK:
            begin
                // later slots overwrite, so the last overdue name wins
                if (active && over)
                begin
                    tok_next.fail    = 1'b1;
                    tok_next.fail_lo = name_lo_reg;
                    tok_next.fail_hi = name_hi_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        name_lo_reg <= name_lo_next;
        name_hi_reg <= name_hi_next;
        tmo_reg     <= tmo_next;
        beat_reg    <= beat_next;
        tok_reg     <= tok_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_tok   = tok_reg;

endmodule

`default_nettype wire

// ===== sv/thm_ctrl.sv =====
// Front end and commit logic: name clean-up, token launch, global state and result register.
`default_nettype none

module thm_ctrl #(
    parameter int MAX_TASKS = 8
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [151:0] s_tdata,
    input  wire logic [1:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [127:0]      m_tdata,
    output logic              launch_valid,
    output thm_pkg::tok_t     launch_tok,
    input  wire logic         ret_valid,
    input  wire thm_pkg::tok_t ret_tok
);
    import thm_pkg::*;

    localparam logic [USED_W-1:0] MAX_USED = USED_W'(MAX_TASKS);

    // Zero every byte that follows the first zero byte
    function automatic logic [NAME_W-1:0] norm_name(input logic [NAME_W-1:0] raw);
        logic [NAME_W-1:0] res;
        logic              keep;
        res = '0;
        for (int i = 0; i < NAME_BYTES; i++)
        begin
            keep = 1'b1;
            for (int j = 0; j < i; j++)
            begin
                if (raw[j*8 +: 8] == 8'd0)
                begin
                    keep = 1'b0;
                end
            end
            if (keep)
            begin
                res[i*8 +: 8] = raw[i*8 +: 8];
            end
        end
        return res;
    endfunction

    logic                 busy_reg, busy_next;
    logic                 launch_valid_reg, launch_valid_next;
    tok_t                 launch_tok_reg, launch_tok_next;
    logic                 pend_valid_reg, pend_valid_next;
    tok_t                 pend_tok_reg, pend_tok_next;
    logic                 out_valid_reg, out_valid_next;
    logic [127:0]         out_data_reg, out_data_next;
    logic [USED_W-1:0]    used_reg, used_next;
    logic [TIME_W-1:0]    time_reg, time_next;
    logic [NAME_LO_W-1:0] failed_lo_reg, failed_lo_next;
    logic [NAME_HI_W-1:0] failed_hi_reg, failed_hi_next;

    logic                 accept;
    logic                 commit;
    logic [NAME_W-1:0]    clean_name;
    logic [STATUS_W-1:0]  status;

    assign accept     = s_tvalid && s_tready;
    assign commit     = pend_valid_reg && (!out_valid_reg || m_tready);
    assign clean_name = norm_name(s_tdata[NAME_W-1:0]);

    always_comb
    begin
        launch_tok_next         = launch_tok_reg;
        launch_tok_next.kind    = s_tuser;
        launch_tok_next.name_lo = clean_name[NAME_LO_W-1:0];
        launch_tok_next.name_hi = clean_name[NAME_W-1:NAME_LO_W];
        launch_tok_next.tmo     = s_tdata[NAME_W +: TIME_W];
        launch_tok_next.now     = time_reg;
        launch_tok_next.used    = used_reg;
        launch_tok_next.found   = 1'b0;
        launch_tok_next.fail    = 1'b0;
        launch_tok_next.fail_lo = '0;
        launch_tok_next.fail_hi = '0;
        launch_valid_next       = accept;
        pend_valid_next         = pend_valid_reg;
        pend_tok_next           = pend_tok_reg;
        busy_next               = busy_reg;
        out_valid_next          = out_valid_reg;
        out_data_next           = out_data_reg;
        used_next               = used_reg;
        time_next               = time_reg;
        failed_lo_next          = failed_lo_reg;
        failed_hi_next          = failed_hi_reg;
        status                  = ST_OK;

        if (accept)
        begin
            busy_next = 1'b1;
        end
        if (ret_valid)
        begin
            pend_valid_next = 1'b1;
            pend_tok_next   = ret_tok;
        end

        case (pend_tok_reg.kind)
            KIND_REG:
            begin
                if (used_reg >= MAX_USED)
                begin
                    status = ST_FULL;
                end
                else if (pend_tok_reg.found)
                begin
                    status = ST_EXISTS;
                end
                else if (commit)
                begin
                    used_next = used_reg + USED_W'(1);
                end
            end
            KIND_BEAT:
            begin
                if (!pend_tok_reg.found)
                begin
                    status = ST_UNKNOWN;
                end
            end
            KIND_CHECK:
            begin
                if (pend_tok_reg.fail)
                begin
                    status = ST_OVERDUE;
                    if (commit)
                    begin
                        failed_lo_next = pend_tok_reg.fail_lo;
                        failed_hi_next = pend_tok_reg.fail_hi;
                    end
                end
            end
            default:
            begin
                if (commit)
                begin
                    time_next = time_reg + TIME_W'(1);
                end
            end
        endcase

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (commit)
        begin
            pend_valid_next = 1'b0;
            busy_next       = 1'b0;
            out_valid_next  = 1'b1;
            out_data_next   = {4'd0, failed_hi_next, failed_lo_next,
                               (failed_lo_next[7:0] != 8'd0), status};
        end
    end

    always_ff @(posedge clk)
    begin
        launch_tok_reg <= launch_tok_next;
        pend_tok_reg   <= pend_tok_next;
        out_data_reg   <= out_data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg         <= 1'b0;
            launch_valid_reg <= 1'b0;
            pend_valid_reg   <= 1'b0;
            out_valid_reg    <= 1'b0;
            used_reg         <= '0;
            time_reg         <= '0;
            failed_lo_reg    <= '0;
            failed_hi_reg    <= '0;
        end
        else
        begin
            busy_reg         <= busy_next;
            launch_valid_reg <= launch_valid_next;
            pend_valid_reg   <= pend_valid_next;
            out_valid_reg    <= out_valid_next;
            used_reg         <= used_next;
            time_reg         <= time_next;
            failed_lo_reg    <= failed_lo_next;
            failed_hi_reg    <= failed_hi_next;
        end
    end

    assign s_tready     = !busy_reg;
    assign m_tvalid     = out_valid_reg;
    assign m_tdata      = out_data_reg;
    assign launch_valid = launch_valid_reg;
    assign launch_tok   = launch_tok_reg;

endmodule

`default_nettype wire

// ===== sv/task_heartbeat_monitor_unit.sv =====
// Top level of the task heartbeat monitor: control front end and a row of slot cells.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-------------------------------------------------
//  s_*     | in  | s_tvalid/s_tready  | tuser: kind; tdata: name_low, name_high, timeout
//  m_*     | out | m_tvalid/m_tready  | tdata: status, failed flag, failed name low/high
//
//  One item at a time: a request token walks the slot cells, one cell per clock.
//  The launch register, each slot cell, the pending register and the output register lie
//  between input and m_tvalid; s_tready returns as m_tvalid rises, so items do not overlap.
//  A waiting result does not block the next input transaction; a second result
//  is held until the output register drains.
//  Reset clears the slot count, time and failed name; slot contents need none.
`default_nettype none

module task_heartbeat_monitor_unit #(
    parameter int MAX_TASKS = 8
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [151:0] s_tdata,   // name_low[63:0], name_high[119:64], timeout_limit[151:120]
    input  wire logic [1:0]   s_tuser,   // kind[1:0]
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [127:0]      m_tdata    // status[2:0], failed_present[3],
                                         // failed_name_low[67:4], failed_name_high[123:68], zero
);
    import thm_pkg::*;

    logic [MAX_TASKS:0] chain_valid;
    tok_t               chain_tok [0:MAX_TASKS];

    thm_ctrl #(
        .MAX_TASKS(MAX_TASKS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .launch_valid(chain_valid[0]),
        .launch_tok  (chain_tok[0]),
        .ret_valid   (chain_valid[MAX_TASKS]),
        .ret_tok     (chain_tok[MAX_TASKS])
    );

    for (genvar g = 0; g < MAX_TASKS; g++)
    begin : g_cell
        thm_cell #(
            .INDEX(g)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .in_valid (chain_valid[g]),
            .in_tok   (chain_tok[g]),
            .out_valid(chain_valid[g+1]),
            .out_tok  (chain_tok[g+1])
        );
    end

    // at most one token in the row
    a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(chain_valid))
        else $error("more than one token in the slot row");

    // ready only with an empty row
    a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> (chain_valid == '0))
        else $error("input ready while a token is in flight");

    // an input transaction launches a token and closes the input
    a_launch: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (chain_valid[0] && !s_tready))
        else $error("input transaction did not launch a token");

endmodule

`default_nettype wire
